// ===== rtl/waf_pkg.sv =====
// windowed average forecast: shared types, register indexes, reset values
// no dependencies; used by the interfaces, the top level and the testbench
package waf_pkg;

    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx REG_HUM_THR  = 2'd0;
    localparam t_cfg_idx REG_TEMP_THR = 2'd1;
    localparam t_cfg_idx REG_PRES_THR = 2'd2;

    localparam t_field HUM_THR_RST  = 16'd5000;
    localparam t_field TEMP_THR_RST = 16'd3000;
    localparam t_field PRES_THR_RST = 16'd150;

    // channel select for the shared divider
    typedef logic [1:0] t_chan;
    localparam t_chan CH_HUM  = 2'd0;
    localparam t_chan CH_TEMP = 2'd1;
    localparam t_chan CH_PRES = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

endpackage

// ===== rtl/waf_if.sv =====
// windowed average forecast: sample, result and configuration channels
// depends on waf_pkg
interface waf_sample_if;
    logic            valid;
    logic            ready;
    waf_pkg::t_field humidity_sample;
    waf_pkg::t_field temperature_sample;
    waf_pkg::t_field pressure_sample;

    modport source (output valid, humidity_sample, temperature_sample, pressure_sample,
                    input ready);
    modport sink   (input valid, humidity_sample, temperature_sample, pressure_sample,
                    output ready);
endinterface

interface waf_result_if;
    logic            valid;
    logic            ready;
    waf_pkg::t_field avg_humidity;
    waf_pkg::t_field avg_temperature;
    waf_pkg::t_field avg_pressure;
    logic            wet_flag;
    logic            hot_flag;
    logic            sunny_flag;

    modport source (output valid, avg_humidity, avg_temperature, avg_pressure,
                    wet_flag, hot_flag, sunny_flag, input ready);
    modport sink   (input valid, avg_humidity, avg_temperature, avg_pressure,
                    wet_flag, hot_flag, sunny_flag, output ready);
endinterface

interface waf_cfg_if;
    logic              valid;
    logic              ready;
    waf_pkg::t_cfg_idx index;
    waf_pkg::t_field   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/waf_div.sv =====
// windowed average forecast: restoring divider, one quotient bit per cycle
// no package dependencies; instantiated by the top level
module waf_div #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_shift;

    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    diff;
    logic              ge;

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_comb begin
        rem_sh = {r_rem, r_shift[SUM_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_div   <= i_divisor;
            r_shift <= i_dividend;
        end else if (r_busy) begin
            r_rem   <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_shift <= {r_shift[SUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_shift;

endmodule

// ===== rtl/windowed_average_forecast_top.sv =====
// windowed average forecast: ring windows, running sums, shared divider, flags
// depends on waf_pkg, the channel interfaces in waf_if and waf_div
//
//   port      | dir | moves
//   ----------+-----+-------------------------------------------------
//   i_sample  | in  | one item: humidity, temperature, pressure sample
//   o_result  | out | one item: three averages and wet/hot/sunny flags
//   i_cfg     | in  | threshold write: register index and 16-bit data
//
// an item passes through update and then one division per channel in turn: the
// one-bit-per-cycle divider runs SUM_W steps for each of the three channels.
// i_sample is ready only while the sequencer is idle; a finished result waits
// in the output register; a later item may wait in done. i_cfg is always ready.
// synchronous active-low reset clears sums, fill count, ring slot and control.
module windowed_average_forecast_top #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    waf_sample_if.sink         i_sample,
    waf_result_if.source       o_result,
    waf_cfg_if.sink            i_cfg
);

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int CMP_W  = (SAMPLE_BITS > waf_pkg::FIELD_W) ? SAMPLE_BITS
                                                              : waf_pkg::FIELD_W;

    waf_pkg::t_state r_state;

    waf_pkg::t_field r_hum_thr;
    waf_pkg::t_field r_temp_thr;
    waf_pkg::t_field r_pres_thr;

    logic [SAMPLE_BITS-1:0] r_new_h, r_new_t, r_new_p;
    logic [SUM_W-1:0]       r_sum_h, r_sum_t, r_sum_p;
    logic [CNT_W-1:0]       r_fill;
    logic [SLOT_W-1:0]      r_slot;
    waf_pkg::t_chan         r_ch;
    logic [SAMPLE_BITS-1:0] r_avg_h, r_avg_t, r_avg_p;

    logic [3*SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [3*SAMPLE_BITS-1:0] r_rd;

    logic                   r_out_valid;
    waf_pkg::t_field        r_out_h, r_out_t, r_out_p;
    logic                   r_wet, r_hot, r_sunny;

    logic                   in_acc;
    logic                   full;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quot;
    logic [SUM_W-1:0]       dividend;
    logic [SAMPLE_BITS-1:0] quot;
    logic                   out_free;

    assign in_acc   = i_sample.valid && i_sample.ready;
    assign full     = (r_fill == CNT_W'(WINDOW));
    assign out_free = !r_out_valid || o_result.ready;
    assign quot     = div_quot[SAMPLE_BITS-1:0];

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hum_thr  <= waf_pkg::HUM_THR_RST;
            r_temp_thr <= waf_pkg::TEMP_THR_RST;
            r_pres_thr <= waf_pkg::PRES_THR_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                waf_pkg::REG_HUM_THR:  r_hum_thr  <= i_cfg.data;
                waf_pkg::REG_TEMP_THR: r_temp_thr <= i_cfg.data;
                waf_pkg::REG_PRES_THR: r_pres_thr <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ring memory: old entry read at the accept edge, new entry written in update
    always_ff @(posedge i_clk) begin
        if (r_state == waf_pkg::ST_UPDATE) begin
            r_mem[r_slot] <= {r_new_p, r_new_t, r_new_h};
        end
        r_rd <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_new_h <= SAMPLE_BITS'(i_sample.humidity_sample);
            r_new_t <= SAMPLE_BITS'(i_sample.temperature_sample);
            r_new_p <= SAMPLE_BITS'(i_sample.pressure_sample);
        end
    end

    always_comb begin
        case (r_ch)
            waf_pkg::CH_HUM:  dividend = r_sum_h;
            waf_pkg::CH_TEMP: dividend = r_sum_t;
            default:          dividend = r_sum_p;
        endcase
    end

    assign div_start = (r_state == waf_pkg::ST_DIV) && !div_busy && !div_done;

    waf_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_fill),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= waf_pkg::ST_IDLE;
            r_sum_h <= '0;
            r_sum_t <= '0;
            r_sum_p <= '0;
            r_fill  <= '0;
            r_slot  <= '0;
            r_ch    <= waf_pkg::CH_HUM;
        end else begin
            unique case (r_state)
                waf_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= waf_pkg::ST_UPDATE;
                    end
                end
                waf_pkg::ST_UPDATE: begin
                    // drop the oldest sample once the window is full
                    r_sum_h <= r_sum_h + SUM_W'(r_new_h)
                             - (full ? SUM_W'(r_rd[SAMPLE_BITS-1:0]) : '0);
                    r_sum_t <= r_sum_t + SUM_W'(r_new_t)
                             - (full ? SUM_W'(r_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0);
                    r_sum_p <= r_sum_p + SUM_W'(r_new_p)
                             - (full ? SUM_W'(r_rd[3*SAMPLE_BITS-1:2*SAMPLE_BITS]) : '0);
                    if (!full) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_slot  <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    r_ch    <= waf_pkg::CH_HUM;
                    r_state <= waf_pkg::ST_DIV;
                end
                waf_pkg::ST_DIV: begin
                    if (div_done) begin
                        if (r_ch == waf_pkg::CH_PRES) begin
                            r_state <= waf_pkg::ST_DONE;
                        end else begin
                            r_ch <= r_ch + 1'b1;
                        end
                    end
                end
                waf_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_state <= waf_pkg::ST_IDLE;
                    end
                end
                default: r_state <= waf_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == waf_pkg::ST_DIV && div_done) begin
            case (r_ch)
                waf_pkg::CH_HUM:  r_avg_h <= quot;
                waf_pkg::CH_TEMP: r_avg_t <= quot;
                default:          r_avg_p <= quot;
            endcase
        end
    end

    assign i_sample.ready = (r_state == waf_pkg::ST_IDLE);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == waf_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == waf_pkg::ST_DONE && out_free) begin
            r_out_h <= waf_pkg::t_field'(r_avg_h);
            r_out_t <= waf_pkg::t_field'(r_avg_t);
            r_out_p <= waf_pkg::t_field'(r_avg_p);
            r_wet   <= CMP_W'(r_avg_h) > CMP_W'(r_hum_thr);
            r_hot   <= CMP_W'(r_avg_t) > CMP_W'(r_temp_thr);
            r_sunny <= CMP_W'(r_avg_p) > CMP_W'(r_pres_thr);
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.avg_humidity    = r_out_h;
    assign o_result.avg_temperature = r_out_t;
    assign o_result.avg_pressure    = r_out_p;
    assign o_result.wet_flag        = r_wet;
    assign o_result.hot_flag        = r_hot;
    assign o_result.sunny_flag      = r_sunny;

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> (CNT_W'(r_slot) == r_fill))
        else $error("ring slot out of step with fill count");

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == waf_pkg::ST_UPDATE))
        else $error("accepted item did not start an update");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_fill != '0))
        else $error("divider started with zero count");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == waf_pkg::ST_DONE && r_state == waf_pkg::ST_IDLE)
            |-> r_out_valid)
        else $error("result not loaded on leaving done");

endmodule

// ===== dv/tb_top.sv =====
// testbench for windowed_average_forecast_top: directed and random sample items,
// threshold rewrites between phases, averages and flags checked against a predictor
// depends on waf_pkg, the channel interfaces in waf_if and the rtl top level
module tb_top;

    localparam int WINDOW         = 20;
    localparam int SUM_W          = 21;
    localparam int IDLE_PCT       = 21;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 184;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    // index with no register behind it, writes to it must be dropped
    localparam waf_pkg::t_cfg_idx REG_SPARE = 2'd3;

    typedef struct packed {
        waf_pkg::t_field avg_humidity;
        waf_pkg::t_field avg_temperature;
        waf_pkg::t_field avg_pressure;
        logic            wet_flag;
        logic            hot_flag;
        logic            sunny_flag;
    } t_forecast;

    typedef struct packed {
        waf_pkg::t_field hum;
        waf_pkg::t_field temp;
        waf_pkg::t_field pres;
        int              copies;
        bit              typed;
        t_forecast       want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    waf_sample_if sample_if();
    waf_result_if result_if();
    waf_cfg_if    cfg_if();

    windowed_average_forecast_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // predictor state
    waf_pkg::t_field  hum_ring  [WINDOW];
    waf_pkg::t_field  temp_ring [WINDOW];
    waf_pkg::t_field  pres_ring [WINDOW];
    logic [SUM_W-1:0] hum_sum, temp_sum, pres_sum;
    int               fill_count, write_slot;
    waf_pkg::t_field  hum_thr, temp_thr, pres_thr;

    t_forecast pending_forecasts[$];
    t_stim_row directed_rows[6];
    bit        no_idle;
    int        items_sent, results_checked, mismatches, settings_used, idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_forecast predict_forecast(input waf_pkg::t_field hum, temp, pres);
        t_forecast        f;
        logic [SUM_W-1:0] ah, at, ap;
        // full window: the slot about to be overwritten holds the oldest sample
        if (fill_count == WINDOW) begin
            hum_sum  -= SUM_W'(hum_ring[write_slot]);
            temp_sum -= SUM_W'(temp_ring[write_slot]);
            pres_sum -= SUM_W'(pres_ring[write_slot]);
        end else begin
            fill_count++;
        end
        hum_ring[write_slot]  = hum;
        temp_ring[write_slot] = temp;
        pres_ring[write_slot] = pres;
        hum_sum  += SUM_W'(hum);
        temp_sum += SUM_W'(temp);
        pres_sum += SUM_W'(pres);
        write_slot = (write_slot == WINDOW - 1) ? 0 : write_slot + 1;
        ah = hum_sum / SUM_W'(fill_count);
        at = temp_sum / SUM_W'(fill_count);
        ap = pres_sum / SUM_W'(fill_count);
        f.avg_humidity    = ah[waf_pkg::FIELD_W-1:0];
        f.avg_temperature = at[waf_pkg::FIELD_W-1:0];
        f.avg_pressure    = ap[waf_pkg::FIELD_W-1:0];
        f.wet_flag        = (ah > SUM_W'(hum_thr));
        f.hot_flag        = (at > SUM_W'(temp_thr));
        f.sunny_flag      = (ap > SUM_W'(pres_thr));
        return f;
    endfunction

    function automatic void queue_forecast(input t_forecast f);
        pending_forecasts = {pending_forecasts, f};
    endfunction

    // a steady run at this value makes the average land right at the threshold edge
    function automatic waf_pkg::t_field near_threshold(input waf_pkg::t_field thr);
        int v;
        v = int'(thr) + int'($urandom_range(2)) - 1;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return waf_pkg::t_field'(v);
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_sample(input waf_pkg::t_field hum, temp, pres, input bit typed,
                               input t_forecast want);
        t_forecast predicted;
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            sample_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        sample_if.valid              <= 1'b1;
        sample_if.humidity_sample    <= hum;
        sample_if.temperature_sample <= temp;
        sample_if.pressure_sample    <= pres;
        do @(posedge i_clk); while (!sample_if.ready);
        predicted = predict_forecast(hum, temp, pres);
        queue_forecast(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic write_threshold(input waf_pkg::t_cfg_idx idx, input waf_pkg::t_field value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            waf_pkg::REG_HUM_THR:  hum_thr  = value;
            waf_pkg::REG_TEMP_THR: temp_thr = value;
            waf_pkg::REG_PRES_THR: pres_thr = value;
            default: ;
        endcase
    endtask

    // stop sending and let every outstanding average come back
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        while (pending_forecasts.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_forecast want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_forecasts.size() == 0) begin
                $error("result item with no expectation pending");
                mismatches++;
            end else begin
                want = pending_forecasts.pop_front();
                check_field("avg_humidity", want.avg_humidity, result_if.avg_humidity);
                check_field("avg_temperature", want.avg_temperature,
                            result_if.avg_temperature);
                check_field("avg_pressure", want.avg_pressure, result_if.avg_pressure);
                check_field("wet_flag", 16'(want.wet_flag), 16'(result_if.wet_flag));
                check_field("hot_flag", 16'(want.hot_flag), 16'(result_if.hot_flag));
                check_field("sunny_flag", 16'(want.sunny_flag), 16'(result_if.sunny_flag));
                results_checked++;
            end
        end
        result_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int              len, kind, phase_start;
        waf_pkg::t_field h, t, p;
        t_forecast       none;

        none            = '0;
        no_idle         = 1'b0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        settings_used   = 1;
        hum_sum         = '0;
        temp_sum        = '0;
        pres_sum        = '0;
        fill_count      = 0;
        write_slot      = 0;
        hum_thr         = waf_pkg::HUM_THR_RST;
        temp_thr        = waf_pkg::TEMP_THR_RST;
        pres_thr        = waf_pkg::PRES_THR_RST;

        i_rst_n                      <= 1'b0;
        sample_if.valid              <= 1'b0;
        sample_if.humidity_sample    <= '0;
        sample_if.temperature_sample <= '0;
        sample_if.pressure_sample    <= '0;
        cfg_if.valid                 <= 1'b0;
        cfg_if.index                 <= waf_pkg::REG_HUM_THR;
        cfg_if.data                  <= '0;

        // typed expectation applies to the last copy of a row
        directed_rows = '{
            // first item after reset: the mean is the sample itself
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b1,
              '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1}},
            '{16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
              '{16'd32767, 16'd32767, 16'd32767, 1'b1, 1'b1, 1'b1}},
            '{16'hFFFF, 16'h0000, 16'hFFFF, 19, 1'b0, '0},
            // window wraps and both opening items are evicted, humidity and pressure sums at their max
            '{16'hFFFF, 16'h0000, 16'hFFFF, 1, 1'b1,
              '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b1}},
            '{16'h0000, 16'hFFFF, 16'h0000, 1, 1'b0, '0},
            '{16'h5555, 16'hAAAA, 16'h00FF, 2, 1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int c = 0; c < directed_rows[r].copies; c++) begin
                send_sample(directed_rows[r].hum, directed_rows[r].temp, directed_rows[r].pres,
                            directed_rows[r].typed && (c == directed_rows[r].copies - 1),
                            directed_rows[r].want);
            end
        end
        drain_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_threshold(waf_pkg::REG_HUM_THR, 16'h0000);
                    write_threshold(waf_pkg::REG_TEMP_THR, 16'h0000);
                    write_threshold(waf_pkg::REG_PRES_THR, 16'h0000);
                end
                1: begin
                    write_threshold(waf_pkg::REG_HUM_THR, 16'hFFFF);
                    write_threshold(REG_SPARE, waf_pkg::t_field'($urandom_range(65535)));
                    write_threshold(waf_pkg::REG_TEMP_THR, 16'hFFFF);
                    write_threshold(waf_pkg::REG_PRES_THR, 16'hFFFF);
                end
                2: begin
                    write_threshold(waf_pkg::REG_HUM_THR, waf_pkg::HUM_THR_RST);
                    write_threshold(waf_pkg::REG_TEMP_THR, waf_pkg::TEMP_THR_RST);
                    write_threshold(waf_pkg::REG_PRES_THR, waf_pkg::PRES_THR_RST);
                end
                default: begin
                    write_threshold(waf_pkg::REG_HUM_THR,
                                    waf_pkg::t_field'($urandom_range(65535)));
                    write_threshold(waf_pkg::REG_TEMP_THR,
                                    waf_pkg::t_field'($urandom_range(65535)));
                    write_threshold(waf_pkg::REG_PRES_THR,
                                    waf_pkg::t_field'($urandom_range(65535)));
                end
            endcase
            cfg_if.valid <= 1'b0;
            settings_used++;
            // one phase runs flat out on both sides
            no_idle     = (phase == 2);
            phase_start = items_sent;

            while (items_sent - phase_start < PHASE_ITEMS) begin
                kind = $urandom_range(3);
                case (kind)
                    0: begin
                        // steady run fills the window so the mean sits on the edge
                        len = $urandom_range(24, 20);
                        h   = near_threshold(hum_thr);
                        t   = near_threshold(temp_thr);
                        p   = near_threshold(pres_thr);
                        repeat (len) send_sample(h, t, p, 1'b0, none);
                    end
                    1: begin
                        len = $urandom_range(30, 10);
                        repeat (len) send_sample(waf_pkg::t_field'($urandom_range(65535)),
                                                 waf_pkg::t_field'($urandom_range(65535)),
                                                 waf_pkg::t_field'($urandom_range(65535)),
                                                 1'b0, none);
                    end
                    2: begin
                        len = $urandom_range(12, 4);
                        repeat (len) send_sample($urandom_range(1) ? 16'hFFFF : 16'h0000,
                                                 $urandom_range(1) ? 16'hFFFF : 16'h0000,
                                                 $urandom_range(1) ? 16'hFFFF : 16'h0000,
                                                 1'b0, none);
                    end
                    default: begin
                        len = $urandom_range(20, 10);
                        repeat (len) send_sample(waf_pkg::t_field'($urandom_range(255)),
                                                 waf_pkg::t_field'($urandom_range(255)),
                                                 waf_pkg::t_field'($urandom_range(255)),
                                                 1'b0, none);
                    end
                endcase
            end
            drain_results();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d sample items sent, %0d forecasts checked, %0d threshold settings",
                 items_sent, results_checked, settings_used);
        $display("%0d mismatches, %0d forecasts still pending", mismatches,
                 pending_forecasts.size());
        if (mismatches == 0 && pending_forecasts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
